@@ rtl/core/a2c_pkg.sv @@
`default_nettype none

package a2c_pkg;

    // default sample width of the coordinate ports
    localparam int IN_WIDTH_DEF = 16;

    // output angle format, signed Q3.ANGLE_FRAC_BITS
    localparam int ANGLE_W         = 16;
    localparam int ANGLE_FRAC_BITS = 13;

    // ratio r in signed Q1.15, quotient carries one extra bit for rounding
    localparam int R_W    = 16;
    localparam int QUOT_W = R_W + 1;
    localparam logic signed [R_W-1:0] R_MAX = {1'b0, {(R_W-1){1'b1}}};

    // polynomial coefficients in Q0.16
    localparam int C3_W = 14;
    localparam int C1_W = 16;
    localparam logic [C3_W-1:0] COEF_C3 = 14'd12865;
    localparam logic [C1_W-1:0] COEF_C1 = 16'd64337;

    // Q61 to Q31 reduction of the cubic term
    localparam int T3_SHIFT = 30;

    // width of the Q31 angle sum and its offsets
    localparam int SUM_W = 36;
    localparam logic signed [SUM_W-1:0] PI_4_Q31  = 36'sd1686629713;
    localparam logic signed [SUM_W-1:0] PI3_4_Q31 = 36'sd5059889139;

    // sign information carried alongside the divider
    typedef struct packed {
        logic num_neg;
        logic x_neg;
        logic y_neg;
    } side_t;

endpackage

`default_nettype wire

@@ rtl/core/atan2_cubic_approximation_top.sv @@
`default_nettype none

// channel   direction  handshake                  payload
// coord     in         coord_valid / coord_stall  x_coord, y_coord
// angle     out        angle_valid / angle_stall  angle
//
// one transfer per clock in and out when not stalled; 26 register stages (two
// input, 17 restoring divider steps, ratio, five multiply/sum/round, output)
// lie between a coord transfer and its angle.
// reset clears only the stage valid bits; no clearing pass is needed.
// a stall only holds stages that carry data, so bubbles close up and the
// block keeps taking coords until every stage is full.

module atan2_cubic_approximation_top
    import a2c_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       coord_valid,
    output logic                       coord_stall,
    input  logic signed [IN_WIDTH-1:0] x_coord,
    input  logic signed [IN_WIDTH-1:0] y_coord,
    output logic                       angle_valid,
    input  logic                       angle_stall,
    output logic signed [ANGLE_W-1:0]  angle
);

    localparam int DEN_W     = IN_WIDTH + 1;
    localparam int EXT_W     = IN_WIDTH + 2;
    localparam int DIV_STEPS = QUOT_W;

    // stage numbering
    localparam int ST_P0  = 0;
    localparam int ST_P1  = 1;
    localparam int ST_D0  = 2;
    localparam int ST_Q   = ST_D0 + DIV_STEPS;
    localparam int ST_M1  = ST_Q + 1;
    localparam int ST_M2  = ST_M1 + 1;
    localparam int ST_M3  = ST_M2 + 1;
    localparam int ST_M4  = ST_M3 + 1;
    localparam int ST_M5  = ST_M4 + 1;
    localparam int ST_OUT = ST_M5 + 1;
    localparam int N_ST   = ST_OUT + 1;

    // datapath widths
    localparam int R2_W  = 2 * R_W;
    localparam int C3R_W = R_W + C3_W + 1;
    localparam int T1_W  = R_W + C1_W + 1;
    localparam int P3_W  = R2_W + C3R_W;
    localparam int T3_W  = P3_W - T3_SHIFT;
    localparam int ANG_SH = 31 - ANGLE_FRAC_BITS;
    localparam int AR_W  = SUM_W - ANG_SH;

    localparam logic [QUOT_W-1:0] QUOT_MAX = QUOT_W'(1) << (QUOT_W - 1);
    localparam logic signed [P3_W-1:0]  HALF3  = P3_W'(1) << (T3_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] HALF_A = SUM_W'(1) << (ANG_SH - 1);
    localparam logic signed [AR_W:0] SAT_HI = (AR_W+1)'(2 ** (ANGLE_W - 1) - 1);
    localparam logic signed [AR_W:0] SAT_LO = (AR_W+1)'(-(2 ** (ANGLE_W - 1)));

    // ---------------------------------------------------------------
    // pipeline control
    // ---------------------------------------------------------------
    logic [N_ST-1:0] vld_reg;
    logic [N_ST-1:0] vld_next;
    logic [N_ST-1:0] en;

    // a stage may load when the output is not stalled or some stage from it to the output is empty
    always_comb
    begin
        for (int i = 0; i < N_ST; i++)
        begin
            en[i] = !angle_stall ||
                    ((vld_reg | ((N_ST'(1) << i) - N_ST'(1))) != {N_ST{1'b1}});
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? coord_valid : vld_reg[0];
        for (int i = 1; i < N_ST; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign coord_stall = !en[ST_P0];
    assign angle_valid = vld_reg[ST_OUT];

    // ---------------------------------------------------------------
    // input stage: |y| + 1 and -x
    // ---------------------------------------------------------------
    logic signed [DEN_W-1:0]    x_ext;
    logic signed [DEN_W-1:0]    y_ext;
    logic signed [DEN_W-1:0]    ay_next;
    logic signed [IN_WIDTH-1:0] x_p0_reg;
    logic signed [DEN_W-1:0]    nx_p0_reg;
    logic signed [DEN_W-1:0]    ay_p0_reg;
    logic                       y_neg_p0_reg;

    assign x_ext   = DEN_W'(x_coord);
    assign y_ext   = DEN_W'(y_coord);
    assign ay_next = y_coord[IN_WIDTH-1] ? (~y_ext + DEN_W'(2)) : (y_ext + DEN_W'(1));

    always_ff @(posedge clk)
    begin
        if (en[ST_P0])
        begin
            x_p0_reg     <= x_coord;
            nx_p0_reg    <= -x_ext;
            ay_p0_reg    <= ay_next;
            y_neg_p0_reg <= y_coord[IN_WIDTH-1];
        end
    end

    // ---------------------------------------------------------------
    // ratio operands: numerator magnitude and denominator
    // ---------------------------------------------------------------
    logic signed [EXT_W-1:0] xe;
    logic signed [EXT_W-1:0] aye;
    logic signed [EXT_W-1:0] nxe;
    logic signed [EXT_W-1:0] den_sel;
    logic signed [EXT_W-1:0] a_sel;
    logic signed [EXT_W-1:0] b_sel;
    logic                    x_neg_p0;
    logic                    num_neg_p0;
    logic [DEN_W-1:0]        mag_p1_reg;
    logic [DEN_W-1:0]        den_p1_reg;
    side_t                   side_p1_reg;

    always_comb
    begin
        xe       = EXT_W'(x_p0_reg);
        aye      = EXT_W'(ay_p0_reg);
        nxe      = EXT_W'(nx_p0_reg);
        x_neg_p0 = x_p0_reg[IN_WIDTH-1];
        if (x_neg_p0)
        begin
            den_sel = aye + nxe;
            a_sel   = xe + aye;
            b_sel   = nxe - aye;
        end
        else
        begin
            den_sel = xe + aye;
            a_sel   = xe - aye;
            b_sel   = aye + nxe;
        end
        num_neg_p0 = a_sel[EXT_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P1])
        begin
            mag_p1_reg          <= num_neg_p0 ? b_sel[DEN_W-1:0] : a_sel[DEN_W-1:0];
            den_p1_reg          <= den_sel[DEN_W-1:0];
            side_p1_reg.num_neg <= num_neg_p0;
            side_p1_reg.x_neg   <= x_neg_p0;
            side_p1_reg.y_neg   <= y_neg_p0_reg;
        end
    end

    // ---------------------------------------------------------------
    // restoring divider, one quotient bit per stage: mag * 2^16 / den
    // ---------------------------------------------------------------
    logic [DEN_W-1:0]  rem_d  [DIV_STEPS];
    logic [DEN_W-1:0]  den_d  [DIV_STEPS];
    logic [QUOT_W-1:0] quot_d [DIV_STEPS];
    side_t             side_d [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            a2c_div_step #(
                .DEN_W (DEN_W),
                .FIRST (1'b1)
            ) u_step (
                .clk      (clk),
                .en       (en[ST_D0]),
                .rem_in   (mag_p1_reg),
                .den_in   (den_p1_reg),
                .quot_in  ({QUOT_W{1'b0}}),
                .side_in  (side_p1_reg),
                .rem_out  (rem_d[0]),
                .den_out  (den_d[0]),
                .quot_out (quot_d[0]),
                .side_out (side_d[0])
            );
        end
        else
        begin : g_rest
            a2c_div_step #(
                .DEN_W (DEN_W),
                .FIRST (1'b0)
            ) u_step (
                .clk      (clk),
                .en       (en[ST_D0+k]),
                .rem_in   (rem_d[k-1]),
                .den_in   (den_d[k-1]),
                .quot_in  (quot_d[k-1]),
                .side_in  (side_d[k-1]),
                .rem_out  (rem_d[k]),
                .den_out  (den_d[k]),
                .quot_out (quot_d[k]),
                .side_out (side_d[k])
            );
        end
    end

    // ---------------------------------------------------------------
    // ratio: round half up, apply sign, clip +1 to just below one
    // ---------------------------------------------------------------
    logic [QUOT_W:0]         q_sum;
    logic [QUOT_W-1:0]       q_mag;
    logic [QUOT_W-1:0]       q_neg;
    logic signed [R_W-1:0]   r_next;
    logic signed [R_W-1:0]   r_q_reg;
    logic                    num_neg_q_reg;
    logic                    x_neg_q_reg;
    logic                    y_neg_q_reg;

    always_comb
    begin
        q_sum = {1'b0, quot_d[DIV_STEPS-1]} + (QUOT_W+1)'(1);
        q_mag = q_sum[QUOT_W:1];
        q_neg = ~q_mag + QUOT_W'(1);
        if (side_d[DIV_STEPS-1].num_neg)
            r_next = q_neg[R_W-1:0];
        else if (q_mag[R_W-1])
            r_next = R_MAX;
        else
            r_next = q_mag[R_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_Q])
        begin
            r_q_reg       <= r_next;
            num_neg_q_reg <= side_d[DIV_STEPS-1].num_neg;
            x_neg_q_reg   <= side_d[DIV_STEPS-1].x_neg;
            y_neg_q_reg   <= side_d[DIV_STEPS-1].y_neg;
        end
    end

    // ---------------------------------------------------------------
    // products: r^2, c3*r, c1*r
    // ---------------------------------------------------------------
    logic signed [R2_W-1:0]  r2_m1_reg;
    logic signed [C3R_W-1:0] c3r_m1_reg;
    logic signed [T1_W-1:0]  t1_m1_reg;
    logic                    x_neg_m1_reg;
    logic                    y_neg_m1_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_M1])
        begin
            r2_m1_reg    <= R2_W'(r_q_reg) * R2_W'(r_q_reg);
            c3r_m1_reg   <= C3R_W'(r_q_reg) * C3R_W'($signed({1'b0, COEF_C3}));
            t1_m1_reg    <= T1_W'(r_q_reg) * T1_W'($signed({1'b0, COEF_C1}));
            x_neg_m1_reg <= x_neg_q_reg;
            y_neg_m1_reg <= y_neg_q_reg;
        end
    end

    // cubic term c3*r^3 in Q61
    logic signed [P3_W-1:0] p3_m2_reg;
    logic signed [T1_W-1:0] t1_m2_reg;
    logic                   x_neg_m2_reg;
    logic                   y_neg_m2_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_M2])
        begin
            p3_m2_reg    <= P3_W'(r2_m1_reg) * P3_W'(c3r_m1_reg);
            t1_m2_reg    <= t1_m1_reg;
            x_neg_m2_reg <= x_neg_m1_reg;
            y_neg_m2_reg <= y_neg_m1_reg;
        end
    end

    // cubic term to Q31, nearest with ties away from zero
    logic signed [P3_W-1:0] rnd3;
    logic signed [T3_W-1:0] t3_m3_reg;
    logic signed [T1_W-1:0] t1_m3_reg;
    logic                   x_neg_m3_reg;
    logic                   y_neg_m3_reg;

    assign rnd3 = p3_m2_reg + HALF3 - {{(P3_W-1){1'b0}}, p3_m2_reg[P3_W-1]};

    always_ff @(posedge clk)
    begin
        if (en[ST_M3])
        begin
            t3_m3_reg    <= rnd3[P3_W-1:T3_SHIFT];
            t1_m3_reg    <= t1_m2_reg;
            x_neg_m3_reg <= x_neg_m2_reg;
            y_neg_m3_reg <= y_neg_m2_reg;
        end
    end

    // quadrant offset plus cubic minus linear term, Q31
    logic signed [SUM_W-1:0] base_sel;
    logic signed [SUM_W-1:0] sum_m4_reg;
    logic                    y_neg_m4_reg;

    assign base_sel = x_neg_m3_reg ? PI3_4_Q31 : PI_4_Q31;

    always_ff @(posedge clk)
    begin
        if (en[ST_M4])
        begin
            sum_m4_reg   <= base_sel + SUM_W'(t3_m3_reg) - SUM_W'(t1_m3_reg);
            y_neg_m4_reg <= y_neg_m3_reg;
        end
    end

    // reduce to the output fraction width, ties away from zero
    logic signed [SUM_W-1:0] rnd_a;
    logic signed [AR_W-1:0]  a_m5_reg;
    logic                    y_neg_m5_reg;

    assign rnd_a = sum_m4_reg + HALF_A - {{(SUM_W-1){1'b0}}, sum_m4_reg[SUM_W-1]};

    always_ff @(posedge clk)
    begin
        if (en[ST_M5])
        begin
            a_m5_reg     <= rnd_a[SUM_W-1:ANG_SH];
            y_neg_m5_reg <= y_neg_m4_reg;
        end
    end

    // mirror for negative y, clip to the port width
    logic signed [AR_W:0]      a_ext;
    logic signed [AR_W:0]      a_sgn;
    logic signed [ANGLE_W-1:0] angle_next;
    logic signed [ANGLE_W-1:0] angle_reg;

    always_comb
    begin
        a_ext = (AR_W+1)'(a_m5_reg);
        a_sgn = y_neg_m5_reg ? -a_ext : a_ext;
        if (a_sgn > SAT_HI)
            angle_next = SAT_HI[ANGLE_W-1:0];
        else if (a_sgn < SAT_LO)
            angle_next = SAT_LO[ANGLE_W-1:0];
        else
            angle_next = a_sgn[ANGLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // the input side only stalls once every stage holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall |-> (&vld_reg))
        else $error("coord stalled with an empty pipeline stage");

    // numerator magnitude never exceeds the denominator
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_D0+DIV_STEPS-1] |-> (quot_d[DIV_STEPS-1] <= QUOT_MAX))
        else $error("divider quotient above 2^16");

    // a non-negative ratio must survive clipping without wrapping
    a_ratio_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_Q] && !num_neg_q_reg) |-> !r_q_reg[R_W-1])
        else $error("positive ratio wrapped negative");

endmodule

`default_nettype wire

@@ rtl/core/a2c_div_step.sv @@
`default_nettype none

module a2c_div_step
    import a2c_pkg::*;
#(
    parameter int DEN_W = IN_WIDTH_DEF + 1,
    parameter bit FIRST = 1'b0
)(
    input  logic              clk,
    input  logic              en,
    input  logic [DEN_W-1:0]  rem_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [QUOT_W-1:0] quot_in,
    input  side_t             side_in,
    output logic [DEN_W-1:0]  rem_out,
    output logic [DEN_W-1:0]  den_out,
    output logic [QUOT_W-1:0] quot_out,
    output side_t             side_out
);

    logic [DEN_W:0]     rem_sh;
    logic [DEN_W+1:0]   diff;
    logic               ge;
    logic [DEN_W-1:0]   rem_next;
    logic [QUOT_W-1:0]  quot_next;

    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [QUOT_W-1:0]  quot_reg;
    side_t              side_reg;

    // one restoring step: the first step compares the unshifted remainder
    always_comb
    begin
        if (FIRST)
            rem_sh = {1'b0, rem_in};
        else
            rem_sh = {rem_in, 1'b0};
        diff      = {1'b0, rem_sh} - {2'b00, den_in};
        ge        = !diff[DEN_W+1];
        rem_next  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quot_next = {quot_in[QUOT_W-2:0], ge};
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quot_reg <= quot_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quot_out = quot_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire
